/* hdl/bcdm_pkg.sv */
// ----------------------------------------------------------------------------
// bcdm_pkg
// shared types and constants of the box center depth median block
// ----------------------------------------------------------------------------
`default_nettype none

package bcdm_pkg;

    localparam int GRID_MAX_W_DEF = 128;
    localparam int GRID_MAX_H_DEF = 128;
    localparam int RADIUS_DEF     = 2;

    localparam int DEPTH_W = 16;
    localparam int IMG_W   = 12;
    localparam int SHIFT_W = 10;
    localparam int GRID_W  = 8;
    localparam int SIZE_W  = 9;
    localparam int CELL_W  = 8;
    localparam int TWO_W   = 14;
    localparam int T_W     = 16;
    localparam int NUM_W   = 26;
    localparam int LIM_W   = 22;
    localparam int REM_W   = 25;
    localparam int DIV_W   = 14;
    localparam int COORD_W = 10;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SHIFT_X      = 3'd2;
    localparam logic [2:0] REG_SHIFT_Y      = 3'd3;
    localparam logic [2:0] REG_DEPTH_LOW    = 3'd4;
    localparam logic [2:0] REG_DEPTH_HIGH   = 3'd5;
    localparam logic [2:0] REG_GRID_WIDTH   = 3'd6;
    localparam logic [2:0] REG_GRID_HEIGHT  = 3'd7;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_SETUP   = 2'd1;
    localparam logic [1:0] STATUS_OUTSIDE = 2'd2;
    localparam logic [1:0] STATUS_EMPTY   = 2'd3;

    localparam logic [1:0] POS_LEFT   = 2'd0;
    localparam logic [1:0] POS_CENTER = 2'd1;
    localparam logic [1:0] POS_RIGHT  = 2'd2;

    localparam logic CMD_WRITE = 1'b0;

    typedef struct packed {
        logic               valid;
        logic [DEPTH_W-1:0] data;
    } sample_t;

endpackage

`default_nettype wire

/* hdl/bcdm_ram.sv */
// ----------------------------------------------------------------------------
// bcdm_ram
// generic simple dual port ram, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module bcdm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* hdl/bcdm_cell.sv */
// ----------------------------------------------------------------------------
// bcdm_cell
// one sorting cell: keeps the smaller sample, hands the larger one on
// ----------------------------------------------------------------------------
`default_nettype none

module bcdm_cell
    import bcdm_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               clear,
    input  wire sample_t            in_sample,
    output sample_t                 out_sample,
    output logic      [DEPTH_W-1:0] hold_data
);

    logic               hold_valid_reg;
    logic [DEPTH_W-1:0] hold_reg;
    sample_t            out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            hold_valid_reg <= 1'b0;
            out_reg.valid  <= 1'b0;
        end else begin
            out_reg.valid <= in_sample.valid && hold_valid_reg;
            if (in_sample.valid) begin
                if (!hold_valid_reg) begin
                    hold_valid_reg <= 1'b1;
                    hold_reg       <= in_sample.data;
                end else if (in_sample.data < hold_reg) begin
                    hold_reg     <= in_sample.data;
                    out_reg.data <= hold_reg;
                end else begin
                    out_reg.data <= in_sample.data;
                end
            end
        end
    end

    assign out_sample = out_reg;
    assign hold_data  = hold_reg;

endmodule

`default_nettype wire

/* hdl/box_center_depth_median_top.sv */
// ----------------------------------------------------------------------------
// box_center_depth_median_top
// depth frame store and median depth lookup at a detection box center
// ----------------------------------------------------------------------------
// A write transfer (tuser 0) stores one depth pixel and gives no result. A
// query transfer (tuser 1) maps the box center onto the depth grid with a
// shared 8-step divider, run once per axis, reads the window one pixel a
// cycle from the frame ram and inserts the passing samples into a row of
// sorting cells, then returns the upper median. A failed setup check answers
// straight from idle, a center outside the grid from the range check of its
// column or row axis. The next transfer can be taken at the edge after the
// result is loaded; a query waits in its last step while an earlier result
// is still held on the result side. The frame ram contents are undefined
// until written.
`default_nettype none

module box_center_depth_median_top
    import bcdm_pkg::*;
#(
    parameter int GRID_MAX_W = GRID_MAX_W_DEF,
    parameter int GRID_MAX_H = GRID_MAX_H_DEF,
    parameter int RADIUS     = RADIUS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pixel_col, pixel_row, pixel_depth, box_x, box_y, box_w, box_h, zero pad
    input  wire logic [79:0] s_tdata,
    // command
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // median depth, position, zero pad
    output logic      [23:0] m_tdata,
    // status
    output logic      [1:0]  m_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int SIDE   = 2 * RADIUS + 1;
    localparam int CELLS  = SIDE * SIDE;
    localparam int ADDR_W = $clog2(GRID_MAX_W * GRID_MAX_H);
    localparam int OFF_W  = $clog2(SIDE + 1);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int IDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int DRN_W  = $clog2(CELLS + 3);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_CHK   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // configuration
    logic [IMG_W-1:0]   img_w_reg, img_h_reg;
    logic [SHIFT_W-1:0] shift_x_reg, shift_y_reg;
    logic [DEPTH_W-1:0] dlow_reg, dhigh_reg;
    logic [GRID_W-1:0]  grid_w_reg, grid_h_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_w_reg   <= IMG_W'(320);
            img_h_reg   <= IMG_W'(320);
            shift_x_reg <= '0;
            shift_y_reg <= '0;
            dlow_reg    <= '0;
            dhigh_reg   <= '1;
            grid_w_reg  <= GRID_W'(100);
            grid_h_reg  <= GRID_W'(100);
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_IMAGE_WIDTH:  img_w_reg   <= pwdata[IMG_W-1:0];
                REG_IMAGE_HEIGHT: img_h_reg   <= pwdata[IMG_W-1:0];
                REG_SHIFT_X:      shift_x_reg <= pwdata[SHIFT_W-1:0];
                REG_SHIFT_Y:      shift_y_reg <= pwdata[SHIFT_W-1:0];
                REG_DEPTH_LOW:    dlow_reg    <= pwdata[DEPTH_W-1:0];
                REG_DEPTH_HIGH:   dhigh_reg   <= pwdata[DEPTH_W-1:0];
                REG_GRID_WIDTH:   grid_w_reg  <= pwdata[GRID_W-1:0];
                REG_GRID_HEIGHT:  grid_h_reg  <= pwdata[GRID_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_IMAGE_WIDTH:  prdata = {20'd0, img_w_reg};
            REG_IMAGE_HEIGHT: prdata = {20'd0, img_h_reg};
            REG_SHIFT_X:      prdata = {22'd0, shift_x_reg};
            REG_SHIFT_Y:      prdata = {22'd0, shift_y_reg};
            REG_DEPTH_LOW:    prdata = {16'd0, dlow_reg};
            REG_DEPTH_HIGH:   prdata = {16'd0, dhigh_reg};
            REG_GRID_WIDTH:   prdata = {24'd0, grid_w_reg};
            REG_GRID_HEIGHT:  prdata = {24'd0, grid_h_reg};
            default:          prdata = '0;
        endcase
    end

    // input fields
    logic [6:0]         in_col, in_row;
    logic [DEPTH_W-1:0] in_depth;
    logic [IMG_W-1:0]   in_bx, in_by, in_bw, in_bh;

    assign in_col   = s_tdata[6:0];
    assign in_row   = s_tdata[13:7];
    assign in_depth = s_tdata[29:14];
    assign in_bx    = s_tdata[41:30];
    assign in_by    = s_tdata[53:42];
    assign in_bw    = s_tdata[65:54];
    assign in_bh    = s_tdata[77:66];

    // grid size clamp
    logic [SIZE_W-1:0] gw, gh;
    always_comb begin
        gw = ({1'b0, grid_w_reg} > SIZE_W'(GRID_MAX_W)) ? SIZE_W'(GRID_MAX_W)
                                                        : {1'b0, grid_w_reg};
        gh = ({1'b0, grid_h_reg} > SIZE_W'(GRID_MAX_H)) ? SIZE_W'(GRID_MAX_H)
                                                        : {1'b0, grid_h_reg};
    end

    // position and setup check at accept time
    logic [IMG_W:0]   center;
    logic [IMG_W+3:0] center3;
    logic [1:0]       pos_in;
    logic             bad_in;

    always_comb begin
        center  = {1'b0, in_bx} + {2'b0, in_bw[IMG_W-1:1]};
        center3 = 16'(({3'b0, center} + 16'd1) * 16'd3);
        if (center3 <= {4'b0, img_w_reg}) begin
            pos_in = POS_LEFT;
        end else if (center3 <= {3'b0, img_w_reg, 1'b0}) begin
            pos_in = POS_CENTER;
        end else begin
            pos_in = POS_RIGHT;
        end
        bad_in = (gw == '0) || (gh == '0) || (img_w_reg == '0) || (img_h_reg == '0)
              || (in_bw == '0) || (in_bh == '0) || (dhigh_reg <= dlow_reg);
    end

    // control
    logic [2:0]              state_reg;
    logic                    axis_reg;
    logic [TWO_W-1:0]        twox_reg, twoy_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic [LIM_W-1:0]        lim_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [DIV_W-1:0]        div_reg;
    logic [2:0]              k_reg;
    logic [CELL_W-1:0]       q_reg, tx_reg, ty_reg;
    logic [OFF_W-1:0]        ox_reg, oy_reg;
    logic [DRN_W-1:0]        drain_reg;
    logic [1:0]              pos_reg, status_reg;
    logic [DEPTH_W-1:0]      depth_res_reg;
    logic                    rd_valid_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    out_valid_reg;
    logic [23:0]             out_data_reg;
    logic [1:0]              out_user_reg;

    logic                    in_xfer, query, clear;
    logic [TWO_W-1:0]        tc;
    logic [SHIFT_W-1:0]      sh;
    logic [SIZE_W-1:0]       sz;
    logic [IMG_W-1:0]        img;
    logic signed [T_W-1:0]   t_val;
    logic [REM_W-1:0]        trial_sub;
    logic [REM_W:0]          trial;
    logic signed [COORD_W-1:0] px, py;
    logic                    in_grid;
    logic [ADDR_W-1:0]       rd_addr, wr_addr;
    logic                    wr_en;
    logic [DEPTH_W-1:0]      rd_data;
    logic                    last_off;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign query    = in_xfer && (s_tuser != CMD_WRITE);
    assign clear    = query;

    always_comb begin
        tc    = axis_reg ? twoy_reg : twox_reg;
        sh    = axis_reg ? shift_y_reg : shift_x_reg;
        sz    = axis_reg ? gh : gw;
        img   = axis_reg ? img_h_reg : img_w_reg;
        t_val = $signed({2'b0, tc}) - $signed({{(T_W-SHIFT_W-1){sh[SHIFT_W-1]}}, sh, 1'b0});
        trial_sub = REM_W'({div_reg, 7'd0} >> (3'd7 - k_reg));
        trial = {1'b0, rem_reg} - {1'b0, trial_sub};
        px = $signed({2'b0, tx_reg}) + $signed({{(COORD_W-OFF_W){1'b0}}, ox_reg})
           - $signed(COORD_W'(RADIUS));
        py = $signed({2'b0, ty_reg}) + $signed({{(COORD_W-OFF_W){1'b0}}, oy_reg})
           - $signed(COORD_W'(RADIUS));
        in_grid = !px[COORD_W-1] && !py[COORD_W-1]
               && (px[SIZE_W-1:0] < gw) && (py[SIZE_W-1:0] < gh);
        rd_addr = ADDR_W'(32'(py[SIZE_W-1:0]) * GRID_MAX_W + 32'(px[SIZE_W-1:0]));
        wr_addr = ADDR_W'(32'(in_row) * GRID_MAX_W + 32'(in_col));
        wr_en   = in_xfer && (s_tuser == CMD_WRITE)
               && (32'(in_col) < GRID_MAX_W) && (32'(in_row) < GRID_MAX_H);
        last_off = (ox_reg == OFF_W'(SIDE - 1)) && (oy_reg == OFF_W'(SIDE - 1));
    end

    bcdm_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (GRID_MAX_W * GRID_MAX_H)
    ) u_frame (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_depth),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // sorting cell row
    sample_t            chain [CELLS+1];
    logic [DEPTH_W-1:0] holds [CELLS];
    logic               feed;
    logic [IDX_W-1:0]   med_idx;

    assign feed           = rd_valid_reg && (rd_data >= dlow_reg) && (rd_data <= dhigh_reg);
    assign chain[0].valid = feed;
    assign chain[0].data  = rd_data;

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        bcdm_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .clear      (clear),
            .in_sample  (chain[g]),
            .out_sample (chain[g+1]),
            .hold_data  (holds[g])
        );
    end

    assign med_idx = IDX_W'(count_reg >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rd_valid_reg  <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= (state_reg == ST_SCAN) && in_grid;
            if (clear) begin
                count_reg <= '0;
            end else if (feed) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (out_valid_reg && m_tready && (state_reg != ST_DONE)) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (query) begin
                        pos_reg       <= pos_in;
                        twox_reg      <= {1'b0, in_bx, 1'b0} + {2'b0, in_bw};
                        twoy_reg      <= {1'b0, in_by, 1'b0} + {2'b0, in_bh};
                        axis_reg      <= 1'b0;
                        depth_res_reg <= '0;
                        if (bad_in) begin
                            status_reg <= STATUS_SETUP;
                            state_reg  <= ST_DONE;
                        end else begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    num_reg   <= NUM_W'(t_val * $signed({1'b0, sz}));
                    lim_reg   <= LIM_W'((sz - SIZE_W'(1)) * {1'b0, img, 1'b0});
                    state_reg <= ST_CHK;
                end
                ST_CHK: begin
                    if (num_reg[NUM_W-1] || (num_reg[NUM_W-2:0] > (NUM_W-1)'(lim_reg))) begin
                        status_reg <= STATUS_OUTSIDE;
                        state_reg  <= ST_DONE;
                    end else begin
                        rem_reg   <= REM_W'({num_reg[NUM_W-2:0], 1'b0}) + REM_W'({img, 1'b0});
                        div_reg   <= {img, 2'b0};
                        k_reg     <= 3'd7;
                        q_reg     <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (!trial[REM_W]) begin
                        rem_reg <= trial[REM_W-1:0];
                    end
                    q_reg[k_reg] <= !trial[REM_W];
                    k_reg        <= k_reg - 3'd1;
                    if (k_reg == 3'd0) begin
                        if (!axis_reg) begin
                            tx_reg    <= {q_reg[CELL_W-1:1], !trial[REM_W]};
                            axis_reg  <= 1'b1;
                            state_reg <= ST_MUL;
                        end else begin
                            ty_reg    <= {q_reg[CELL_W-1:1], !trial[REM_W]};
                            ox_reg    <= '0;
                            oy_reg    <= '0;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (ox_reg == OFF_W'(SIDE - 1)) begin
                        ox_reg <= '0;
                        oy_reg <= oy_reg + OFF_W'(1);
                    end else begin
                        ox_reg <= ox_reg + OFF_W'(1);
                    end
                    if (last_off) begin
                        drain_reg <= DRN_W'(CELLS + 2);
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    drain_reg <= drain_reg - DRN_W'(1);
                    if (drain_reg == '0) begin
                        if (count_reg == '0) begin
                            status_reg    <= STATUS_EMPTY;
                            depth_res_reg <= '0;
                        end else begin
                            status_reg    <= STATUS_OK;
                            depth_res_reg <= holds[med_idx];
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {6'd0, pos_reg, depth_res_reg};
                        out_user_reg  <= status_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire
